// ----- src/first_fit_partition_allocator_macros.svh -----
// Assertion macros used by the partition allocator top level.
`ifndef FIRST_FIT_PARTITION_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_PARTITION_ALLOCATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FFPA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FFPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/ffpa_pkg.sv -----
// Package with the shared types and constants of the partition allocator.
`default_nettype none
package ffpa_pkg;

    // Table and memory defaults.
    localparam int MAX_ENTRIES_DEF = 16;
    localparam int MEM_BYTES       = 4096;

    // Field widths.
    localparam int ID_W    = 8;
    localparam int ADDR_W  = 13;
    localparam int REQ_W   = 16;
    localparam int STAT_W  = 3;

    // Identifier that marks free space.
    localparam logic [ID_W-1:0] FREE_MARK = 8'h2F;

    // Depth of the request queue between front and back.
    localparam int Q_DEPTH = 2;

    typedef enum logic {
        KIND_ALLOC = 1'b0,
        KIND_FREE  = 1'b1
    } t_ffpa_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_REJECT   = 3'd1,
        ST_NOFIT    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_FULL     = 3'd4
    } t_ffpa_status;

    // One classified request as it travels from front to back.
    typedef struct packed {
        t_ffpa_kind        kind;
        logic [ID_W-1:0]   id;
        logic [REQ_W-1:0]  size;
    } t_ffpa_req;

    // One partition table entry as stored in the RAM.
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] size;
        logic              free;
    } t_ffpa_entry;

endpackage
`default_nettype wire

// ----- src/ffpa_ram.sv -----
// Generic simple dual-port RAM with registered read.
`default_nettype none
module ffpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ----- src/ffpa_front.sv -----
// Front end: accepts request beats, classifies them and queues them for the back end.
`default_nettype none
module ffpa_front
    import ffpa_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic              i_type,
    input  wire logic [ID_W-1:0]   i_id,
    input  wire logic [REQ_W-1:0]  i_size,
    output logic                   o_req_valid,
    output t_ffpa_req              o_req,
    input  wire logic              i_req_pop
);

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int FILL_W = $clog2(Q_DEPTH + 1);

    t_ffpa_req          r_q [Q_DEPTH];
    logic [PTR_W-1:0]   r_wptr;
    logic [PTR_W-1:0]   r_rptr;
    logic [FILL_W-1:0]  r_fill;
    t_ffpa_req          w_in;
    logic               w_push;
    logic               w_pop;

    // Classify the incoming beat.
    always_comb begin
        w_in.kind = i_type ? KIND_FREE : KIND_ALLOC;
        w_in.id   = i_id;
        w_in.size = i_size;
    end

    assign o_ready     = (r_fill != FILL_W'(Q_DEPTH));
    assign w_push      = i_valid && o_ready;
    assign o_req_valid = (r_fill != '0);
    assign w_pop       = i_req_pop && o_req_valid;
    assign o_req       = r_q[r_rptr];

    // Queue storage; no reset needed on the payload.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wptr] <= w_in;
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_fill <= r_fill + 1'b1;
                2'b01:   r_fill <= r_fill - 1'b1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- src/ffpa_back.sv -----
// Back end: scans the partition table in RAM and carries out each request.
`default_nettype none
module ffpa_back
    import ffpa_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [ADDR_W-1:0]                  i_cfg_wdata,
    input  wire logic                               i_req_valid,
    input  t_ffpa_req                               i_req,
    output logic                                    o_req_pop,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic [STAT_W-1:0]                       o_status,
    output logic [ADDR_W-1:0]                       o_start,
    output logic [$clog2(MAX_ENTRIES + 1)-1:0]      o_count
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_CHECK,
        S_WR_NEW,
        S_WR_FIT,
        S_RESP
    } t_state;

    t_state             r_state;
    t_ffpa_req          r_req;
    logic [ADDR_W-1:0]  r_mem_size;
    logic [CNT_W-1:0]   r_count;
    logic [IDX_W-1:0]   r_idx;
    logic               r_dup;
    logic               r_fit;
    logic [IDX_W-1:0]   r_fit_idx;
    logic [ADDR_W-1:0]  r_fit_start;
    logic [ADDR_W-1:0]  r_fit_size;
    t_ffpa_status       r_status;
    logic [ADDR_W-1:0]  r_start;
    logic               r_valid;
    logic [STAT_W-1:0]  r_out_status;
    logic [ADDR_W-1:0]  r_out_start;

    logic               w_we;
    logic [IDX_W-1:0]   w_waddr;
    t_ffpa_entry        w_wdata;
    logic               w_re;
    t_ffpa_entry        w_rd;
    logic               w_last;
    logic               w_id_hit;
    logic               w_fits;
    logic               n_dup;
    logic               n_fit;
    logic [ADDR_W-1:0]  w_cfg_sat;

    ffpa_ram #(
        .WIDTH ($bits(t_ffpa_entry)),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_idx),
        .o_rdata (w_rd)
    );

    // Saturate a written memory size to the managed range.
    assign w_cfg_sat = (32'(i_cfg_wdata) > MEM_BYTES) ? ADDR_W'(MEM_BYTES) : i_cfg_wdata;

    // Compare the entry just read against the request.
    assign w_last   = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);
    assign w_id_hit = (w_rd.id == r_req.id);
    assign w_fits   = w_rd.free && ({{(REQ_W - ADDR_W){1'b0}}, w_rd.size} >= r_req.size);
    assign n_dup    = r_dup || w_id_hit;
    assign n_fit    = r_fit || w_fits;

    // RAM port control follows the state.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_fit_idx;
        w_wdata = '0;
        w_re    = (r_state == S_READ);
        unique case (r_state)
            S_INIT: begin
                w_we          = 1'b1;
                w_waddr       = '0;
                w_wdata.id    = FREE_MARK;
                w_wdata.start = '0;
                w_wdata.size  = r_mem_size;
                w_wdata.free  = 1'b1;
            end
            S_WR_NEW: begin
                w_we          = 1'b1;
                w_waddr       = r_count[IDX_W-1:0];
                w_wdata.id    = r_req.id;
                w_wdata.start = r_fit_start;
                w_wdata.size  = r_req.size[ADDR_W-1:0];
                w_wdata.free  = 1'b0;
            end
            S_WR_FIT: begin
                // Shrink the chosen free entry, or turn a freed entry into free space.
                w_we          = 1'b1;
                w_waddr       = r_fit_idx;
                w_wdata.id    = FREE_MARK;
                w_wdata.free  = 1'b1;
                if (r_req.kind == KIND_ALLOC) begin
                    w_wdata.start = r_fit_start + r_req.size[ADDR_W-1:0];
                    w_wdata.size  = r_fit_size - r_req.size[ADDR_W-1:0];
                end else begin
                    w_wdata.start = r_fit_start;
                    w_wdata.size  = r_fit_size;
                end
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    assign o_req_pop = (r_state == S_IDLE) && !i_cfg_we;

    // Sequencer with its registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_mem_size <= ADDR_W'(MEM_BYTES);
            r_count    <= CNT_W'(1);
            r_valid    <= 1'b0;
        end else begin
            // A drained result is cleared here unless the response state refills it.
            if (r_valid && i_ready && (i_cfg_we || (r_state != S_RESP))) begin
                r_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_mem_size <= w_cfg_sat;
                r_count    <= CNT_W'(1);
                r_state    <= S_INIT;
            end else begin
                unique case (r_state)
                    S_INIT: begin
                        r_count <= CNT_W'(1);
                        r_state <= S_IDLE;
                    end
                    S_IDLE: begin
                        if (i_req_valid) begin
                            r_req   <= i_req;
                            r_idx   <= '0;
                            r_dup   <= 1'b0;
                            r_fit   <= 1'b0;
                            r_start <= '0;
                            r_state <= S_READ;
                        end
                    end
                    S_READ: begin
                        r_state <= S_CHECK;
                    end
                    S_CHECK: begin
                        if (r_req.kind == KIND_ALLOC) begin
                            r_dup <= n_dup;
                            r_fit <= n_fit;
                            if (!r_fit && w_fits) begin
                                r_fit_idx   <= r_idx;
                                r_fit_start <= w_rd.start;
                                r_fit_size  <= w_rd.size;
                            end
                            if (!w_last) begin
                                r_idx   <= r_idx + 1'b1;
                                r_state <= S_READ;
                            end else if (n_dup) begin
                                r_status <= ST_REJECT;
                                r_state  <= S_RESP;
                            end else if (r_req.size > {{(REQ_W - ADDR_W){1'b0}}, r_mem_size}) begin
                                r_status <= ST_REJECT;
                                r_state  <= S_RESP;
                            end else if (!n_fit) begin
                                r_status <= ST_NOFIT;
                                r_state  <= S_RESP;
                            end else if (r_count == CNT_W'(MAX_ENTRIES)) begin
                                r_status <= ST_FULL;
                                r_state  <= S_RESP;
                            end else begin
                                r_status <= ST_OK;
                                r_state  <= S_WR_NEW;
                            end
                        end else begin
                            if (!w_rd.free && w_id_hit) begin
                                r_fit_idx   <= r_idx;
                                r_fit_start <= w_rd.start;
                                r_fit_size  <= w_rd.size;
                                r_status    <= ST_OK;
                                r_state     <= S_WR_FIT;
                            end else if (w_last) begin
                                r_status <= ST_NOTFOUND;
                                r_state  <= S_RESP;
                            end else begin
                                r_idx   <= r_idx + 1'b1;
                                r_state <= S_READ;
                            end
                        end
                    end
                    S_WR_NEW: begin
                        r_count <= r_count + 1'b1;
                        r_start <= r_fit_start;
                        r_state <= S_WR_FIT;
                    end
                    S_WR_FIT: begin
                        r_state <= S_RESP;
                    end
                    S_RESP: begin
                        // Load the result register once it is empty or being drained.
                        if (!r_valid || i_ready) begin
                            r_valid      <= 1'b1;
                            r_out_status <= r_status;
                            r_out_start  <= r_start;
                            r_state      <= S_IDLE;
                        end
                    end
                    default: begin
                        r_state <= S_IDLE;
                    end
                endcase
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_status = r_out_status;
    assign o_start  = r_out_start;
    assign o_count  = r_count;

endmodule
`default_nettype wire

// ----- src/first_fit_partition_allocator.sv -----
// Top level of the first-fit partition allocator.
//
// Request beats arrive on the s_axis channel: tuser carries the request type
// (allocate or free), tdata the partition id and the requested size. Each
// request gives exactly one result beat on the m_axis channel with a status
// code and, for a successful allocate, the start of the new partition.
// The partition table sits in a RAM with a registered read port, so every
// entry scanned passes through a read state and a check state. A request is
// taken from the queue in the idle state; an allocate then scans all n
// entries and, on success, writes the new entry and the shrunk free entry
// before the response; a free stops at the first match. Requests are worked
// on one at a time. A two-beat queue in front of the sequencer takes new
// requests meanwhile, and the result register holds its beat while the
// receiver stalls; the sequencer waits only when that register is still full.
// After reset, and after each write of memory_size, the table holds one free
// partition covering the whole memory, written in the init state. The user
// must write memory_size only while the block is idle; the block itself
// does not enforce this.
`default_nettype none
`include "first_fit_partition_allocator_macros.svh"
module first_fit_partition_allocator
    import ffpa_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [ADDR_W-1:0]  i_cfg_wdata,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [23:0]        s_axis_tdata,   // part_id [7:0], request_size [23:8]
    input  wire logic [0:0]         s_axis_tuser,   // req_type [0]
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [15:0]             m_axis_tdata    // status [2:0], start_addr [15:3]
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    logic               w_req_valid;
    t_ffpa_req          w_req;
    logic               w_req_pop;
    logic [STAT_W-1:0]  w_status;
    logic [ADDR_W-1:0]  w_start;
    logic [CNT_W-1:0]   w_count;
    logic               w_count_ok;
    logic               w_count_one;
    logic               w_status_ok;
    logic               w_start_ok;

    // Front end: accept and classify request beats.
    ffpa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_type      (s_axis_tuser[0]),
        .i_id        (s_axis_tdata[7:0]),
        .i_size      (s_axis_tdata[23:8]),
        .o_req_valid (w_req_valid),
        .o_req       (w_req),
        .i_req_pop   (w_req_pop)
    );

    // Back end: table scan and update.
    ffpa_back #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req_valid (w_req_valid),
        .i_req       (w_req),
        .o_req_pop   (w_req_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_status    (w_status),
        .o_start     (w_start),
        .o_count     (w_count)
    );

    assign m_axis_tdata = {w_start, w_status};

    // Conditions watched by the checks below.
    assign w_count_ok  = (w_count >= CNT_W'(1)) && (w_count <= CNT_W'(MAX_ENTRIES));
    assign w_count_one = (w_count == CNT_W'(1));
    assign w_status_ok = (w_status <= ST_FULL);
    assign w_start_ok  = (w_status == ST_OK) || (w_start == '0);

    // The table always holds between one and MAX_ENTRIES entries.
    `FFPA_ASSERT_NOW(a_count_range, i_clk, i_rst_n, 1'b1, w_count_ok, "entry count out of range")
    // A configuration write leaves a single free partition.
    `FFPA_ASSERT_NEXT(a_cfg_reinit, i_clk, i_rst_n, i_cfg_we, w_count_one, "table not reset")
    // Only defined status codes are reported.
    `FFPA_ASSERT_NOW(a_status_code, i_clk, i_rst_n, m_axis_tvalid, w_status_ok, "bad status code")
    // A start address is only reported with an ok status.
    `FFPA_ASSERT_NOW(a_start_zero, i_clk, i_rst_n, m_axis_tvalid, w_start_ok, "start not zero")

endmodule
`default_nettype wire

// ----- bench/tb.sv -----
// Self-checking testbench for the first-fit partition allocator.
`timescale 1ns / 100ps
module tb;
    import ffpa_pkg::*;

    // Expected outcome of one request.
    typedef struct {
        t_ffpa_status       status;
        logic [ADDR_W-1:0]  start;
    } t_outcome;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [ADDR_W-1:0]  i_cfg_wdata = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [23:0]        s_axis_tdata = '0;     // part_id [7:0], request_size [23:8]
    logic [0:0]         s_axis_tuser = '0;     // req_type [0]
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [15:0]        m_axis_tdata;          // status [2:0], start_addr [15:3]

    // Shadow copy of the partition table.
    t_ffpa_entry        part_table [MAX_ENTRIES_DEF];
    int                 part_count;
    logic [ADDR_W-1:0]  mem_bytes;

    // Requests waiting to be sent and outcomes waiting to be seen.
    t_ffpa_req          request_queue [$];
    t_outcome           expected_outcomes [$];
    t_ffpa_req          next_req;
    t_outcome           want;

    // Generator side: memory size in force and ids handed out so far.
    logic [ADDR_W-1:0]  gen_mem;
    logic [ID_W-1:0]    issued_ids [$];

    int unsigned        idle_pct = 21;
    int                 mismatch_count = 0;

    first_fit_partition_allocator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Writing the memory size clears the table to one free partition.
    function automatic void set_memory_size(input logic [ADDR_W-1:0] value);
        int i;
        mem_bytes = (value > MEM_BYTES) ? ADDR_W'(MEM_BYTES) : value;
        for (i = 0; i < MAX_ENTRIES_DEF; i++) begin
            part_table[i] = '0;
        end
        part_table[0].id    = FREE_MARK;
        part_table[0].start = '0;
        part_table[0].size  = mem_bytes;
        part_table[0].free  = 1'b1;
        part_count = 1;
    endfunction

    // First-fit allocation: duplicate and size checks, then the fit search, then capacity.
    function automatic t_ffpa_status allocate_partition(input logic [ID_W-1:0] id,
                                                        input logic [REQ_W-1:0] len,
                                                        output logic [ADDR_W-1:0] base);
        int i;
        int n;
        base = '0;
        n = part_count;
        for (i = 0; i < n; i++) begin
            if (part_table[i].id == id)
                return ST_REJECT;
        end
        if (len > mem_bytes)
            return ST_REJECT;
        for (i = 0; i < n; i++) begin
            if (part_table[i].free && part_table[i].size >= len) begin
                if (n >= MAX_ENTRIES_DEF)
                    return ST_FULL;
                part_table[n].id    = id;
                part_table[n].start = part_table[i].start;
                part_table[n].size  = len[ADDR_W-1:0];
                part_table[n].free  = 1'b0;
                part_count = n + 1;
                base = part_table[i].start;
                part_table[i].start = part_table[i].start + len[ADDR_W-1:0];
                part_table[i].size  = part_table[i].size - len[ADDR_W-1:0];
                return ST_OK;
            end
        end
        return ST_NOFIT;
    endfunction

    // Freeing marks the first used entry with that id as free space; no merging.
    function automatic t_ffpa_status free_partition(input logic [ID_W-1:0] id);
        int i;
        for (i = 0; i < part_count; i++) begin
            if (!part_table[i].free && part_table[i].id == id) begin
                part_table[i].free = 1'b1;
                part_table[i].id   = FREE_MARK;
                return ST_OK;
            end
        end
        return ST_NOTFOUND;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, exp_val);
    endtask

    task automatic queue_request(input t_ffpa_kind kind, input logic [ID_W-1:0] id,
                                 input logic [REQ_W-1:0] len);
        t_ffpa_req req;
        req.kind = kind;
        req.id   = id;
        req.size = len;
        request_queue.push_back(req);
    endtask

    // Random mix: mostly fresh allocations and frees of live ids, some duplicates and strays.
    task automatic add_random_requests(input int count);
        int pick;
        int k;
        logic [ID_W-1:0]  id;
        logic [REQ_W-1:0] len;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                id = ID_W'($urandom_range(255));
                k = $urandom_range(99);
                if (k < 60)
                    len = REQ_W'($urandom_range(0, gen_mem / 4));
                else if (k < 75)
                    len = REQ_W'($urandom_range(0, gen_mem));
                else if (k < 85)
                    len = REQ_W'($urandom_range(0, 65535));
                else if (k < 92)
                    len = '0;
                else
                    len = REQ_W'(gen_mem);
                queue_request(KIND_ALLOC, id, len);
                issued_ids.push_back(id);
            end else if (pick < 58 && issued_ids.size() > 0) begin
                k = $urandom_range(issued_ids.size() - 1);
                queue_request(KIND_ALLOC, issued_ids[k], REQ_W'($urandom_range(0, gen_mem)));
            end else if (pick < 88 && issued_ids.size() > 0) begin
                k = $urandom_range(issued_ids.size() - 1);
                queue_request(KIND_FREE, issued_ids[k], REQ_W'($urandom_range(0, 65535)));
                issued_ids.delete(k);
            end else begin
                queue_request(KIND_FREE, ID_W'($urandom_range(255)),
                              REQ_W'($urandom_range(0, 65535)));
            end
        end
    endtask

    // Idle means nothing queued, nothing on the input bus and nothing outstanding.
    task automatic wait_until_idle();
        @(negedge i_clk);
        while (request_queue.size() != 0 || s_axis_tvalid || expected_outcomes.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_memory_size(input logic [ADDR_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        set_memory_size(value);
        gen_mem = mem_bytes;
        @(negedge i_clk);
    endtask

    // Request driver: predicts each accepted beat, then offers the next one or idles.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (t_ffpa_kind'(s_axis_tuser[0]) == KIND_ALLOC) begin
                    want.status = allocate_partition(s_axis_tdata[7:0], s_axis_tdata[23:8],
                                                     want.start);
                end else begin
                    want.status = free_partition(s_axis_tdata[7:0]);
                    want.start  = '0;
                end
                expected_outcomes.push_back(want);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (request_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    next_req = request_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {next_req.size, next_req.id};
                    s_axis_tuser  <= next_req.kind;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: stalls at random and checks each beat against the oldest outcome.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= idle_pct);
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_outcomes.size() == 0) begin
                    report_mismatch("result beat with nothing outstanding",
                                    int'(m_axis_tdata), 0);
                end else begin
                    automatic t_outcome exp_out = expected_outcomes.pop_front();
                    if (m_axis_tdata[2:0] != exp_out.status)
                        report_mismatch("status", int'(m_axis_tdata[2:0]),
                                        int'(exp_out.status));
                    if (m_axis_tdata[15:3] != exp_out.start)
                        report_mismatch("start_addr", int'(m_axis_tdata[15:3]),
                                        int'(exp_out.start));
                end
            end
        end
    end

    // Stimulus: directed requests after reset, then random phases under several sizes.
    initial begin
        int k;
        int ph;
        logic [ADDR_W-1:0] cfg_value;
        set_memory_size(ADDR_W'(MEM_BYTES));
        gen_mem = mem_bytes;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Rejections: the free-space id, and sizes above the memory.
        queue_request(KIND_ALLOC, FREE_MARK, 16'd10);
        queue_request(KIND_ALLOC, 8'h01, 16'd4097);
        queue_request(KIND_ALLOC, 8'h02, 16'hFFFF);
        // A zero-size allocation succeeds; its id then counts as a duplicate.
        queue_request(KIND_ALLOC, 8'h03, 16'd0);
        queue_request(KIND_ALLOC, 8'h03, 16'd5);
        queue_request(KIND_ALLOC, 8'hFF, 16'd100);
        // Frees of an unknown id, of the free-space id, and a double free.
        queue_request(KIND_FREE, 8'h55, 16'hFFFF);
        queue_request(KIND_FREE, FREE_MARK, 16'd0);
        queue_request(KIND_FREE, 8'hFF, 16'd0);
        queue_request(KIND_FREE, 8'hFF, 16'd0);
        // Use up the tail, so the freed hole is taken next; then a request too big for it.
        queue_request(KIND_ALLOC, 8'h00, 16'd50);
        queue_request(KIND_ALLOC, 8'hAA, 16'd3946);
        queue_request(KIND_ALLOC, 8'h11, 16'd60);
        queue_request(KIND_ALLOC, 8'h12, 16'd41);
        // Zero size at the exhausted tail returns the very top address.
        queue_request(KIND_ALLOC, 8'h13, 16'd0);
        // Fill the table, then requests while full: one that fits, one that does not fit, and one that fits.
        for (k = 0; k < 9; k++)
            queue_request(KIND_ALLOC, ID_W'(8'h20 + k), 16'd0);
        queue_request(KIND_ALLOC, 8'h29, 16'd0);
        queue_request(KIND_ALLOC, 8'h2A, 16'd100);
        queue_request(KIND_ALLOC, 8'h2B, 16'd40);
        wait_until_idle();

        // Random phases, each after a fresh memory size; one runs without any idling.
        for (ph = 0; ph < 14; ph++) begin
            case (ph)
                0: cfg_value = '0;
                1: cfg_value = 13'd1;
                2: cfg_value = '1;
                3: cfg_value = 13'd4096;
                5: cfg_value = ADDR_W'($urandom_range(4097, 8191));
                default: begin
                    if (ph % 2 == 1)
                        cfg_value = ADDR_W'($urandom_range(1, 64));
                    else
                        cfg_value = ADDR_W'($urandom_range(65, 4096));
                end
            endcase
            write_memory_size(cfg_value);
            idle_pct <= (ph == 6) ? 0 : 21;
            add_random_requests($urandom_range(24, 40));
            wait_until_idle();
        end

        repeat (60) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+src
src/ffpa_pkg.sv
src/ffpa_ram.sv
src/ffpa_front.sv
src/ffpa_back.sv
src/first_fit_partition_allocator.sv
bench/tb.sv
